/* design/evad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy VAD package
// Shared widths, register indexes, reset values and channel word types.
// ----------------------------------------------------------------------------
package evad_pkg;

   localparam int unsigned MAX_FRAME_LEN = 1024;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned LEN_W       = 11;
   localparam int unsigned FACTOR_W    = 12;
   localparam int unsigned WEIGHT_W    = 16;
   localparam int unsigned FLOOR_W     = 24;
   localparam int unsigned OUT_FLOOR_W = 23;
   localparam int unsigned SUM_W       = 41;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_FACTOR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GATE_FACTOR      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACKING_WEIGHT  = 2'd3;

   localparam logic [LEN_W-1:0]    FRAME_LENGTH_RESET     = 11'd320;
   localparam logic [FACTOR_W-1:0] THRESHOLD_FACTOR_RESET = 12'd768;
   localparam logic [FACTOR_W-1:0] GATE_FACTOR_RESET      = 12'd307;
   localparam logic [WEIGHT_W-1:0] TRACKING_WEIGHT_RESET  = 16'd3277;
   localparam logic [FLOOR_W-1:0]  FLOOR_RESET            = 24'd25600;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       chunk_end;
   } req_word_type;

   typedef struct packed {
      logic                   speech_active;
      logic                   speech_started;
      logic                   speech_ended;
      logic [OUT_FLOOR_W-1:0] noise_floor;
   } rsp_word_type;

endpackage

/* design/energy_voice_activity_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy voice activity detector
// Frame energy to RMS by divider, root and shared multiplier steps; noise
// floor tracking and per-chunk speech state with start and end events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  req     | in        | req_valid / req_stall | sample, chunk_end
//  rsp     | out       | rsp_valid / rsp_stall | speech flags, noise_floor
//  csr     | in        | csr_write             | csr_index, csr_wdata
//
//  A sample inside a frame is squared, then accumulated; once the chunk
//  already holds speech it skips both. A frame close runs the 41-step
//  divider and 24-step root and may update the floor; chunk end adds ST_OUT.
//  Synchronous reset restores register defaults and a floor of 100.0.
//  Results sit in an output register; a new one waits only while the
//  previous word is still stalled.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  evad_pkg::req_word_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output evad_pkg::rsp_word_type              rsp_data,
   input  logic                                csr_write,
   input  logic [evad_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [evad_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import evad_pkg::*;

   localparam int unsigned MUL_A_W   = 24;
   localparam int unsigned MUL_B_W   = 17;
   localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
   localparam int unsigned DIV_REM_W = 10;
   localparam int unsigned SQ_W      = 48;
   localparam int unsigned ROOT_W    = SQ_W / 2;
   localparam int unsigned SQ_REM_W  = ROOT_W + 1;
   localparam int unsigned MEAN_W    = 31;
   localparam int unsigned CNT_W     = 6;

   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SUM_W - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
   localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_FRAME_LEN);
   localparam logic [FLOOR_W-1:0] OUT_FLOOR_MAX = {1'b0, {OUT_FLOOR_W{1'b1}}};

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SQUARE   = 4'd1;
   localparam logic [3:0] ST_ACCUM    = 4'd2;
   localparam logic [3:0] ST_DIV      = 4'd3;
   localparam logic [3:0] ST_SQRT     = 4'd4;
   localparam logic [3:0] ST_GATE     = 4'd5;
   localparam logic [3:0] ST_GATE_CMP = 4'd6;
   localparam logic [3:0] ST_UPD_A    = 4'd7;
   localparam logic [3:0] ST_UPD_B    = 4'd8;
   localparam logic [3:0] ST_UPD_C    = 4'd9;
   localparam logic [3:0] ST_THR      = 4'd10;
   localparam logic [3:0] ST_THR_CMP  = 4'd11;
   localparam logic [3:0] ST_OUT      = 4'd12;

   logic [3:0]             state_ff, state_in;
   logic [LEN_W-1:0]       frame_length_ff, frame_length_in;
   logic [FACTOR_W-1:0]    threshold_ff, threshold_in;
   logic [FACTOR_W-1:0]    gate_ff, gate_in;
   logic [WEIGHT_W-1:0]    weight_ff, weight_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [LEN_W-1:0]       fill_ff, fill_in;
   logic [FLOOR_W-1:0]     floor_ff, floor_in;
   logic                   speech_on_ff, speech_on_in;
   logic                   seen_ff, seen_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_data_ff, rsp_data_in;

   logic [SAMPLE_W-1:0]    mag_ff, mag_in;
   logic                   last_ff, last_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SUM_W-1:0]       div_q_ff, div_q_in;
   logic [DIV_REM_W-1:0]   div_rem_ff, div_rem_in;
   logic [SQ_W-1:0]        sq_val_ff, sq_val_in;
   logic [SQ_REM_W-1:0]    sq_rem_ff, sq_rem_in;
   logic [ROOT_W-1:0]      root_ff, root_in;

   logic [LEN_W-1:0]       eff_len;
   logic [SAMPLE_W-1:0]    req_mag;
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [PROD_W-1:0]      mul_p;
   logic [SUM_W-1:0]       acc_sum;
   logic [LEN_W-1:0]       fill_next;
   logic [LEN_W-1:0]       div_trial;
   logic                   div_ge;
   logic [DIV_REM_W-1:0]   div_rem_next;
   logic [SUM_W-1:0]       div_q_next;
   logic [SQ_REM_W+1:0]    sq_trial;
   logic [SQ_REM_W+1:0]    sq_test;
   logic                   sq_ge;
   logic [SQ_REM_W-1:0]    sq_rem_next;
   logic [ROOT_W-1:0]      root_next;
   logic [PROD_W-1:0]      rms_scaled;
   logic [PROD_W:0]        upd_sum;
   logic                   req_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (frame_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (frame_length_ff > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = frame_length_ff;
      end
   end

   assign req_mag = req_data.sample[SAMPLE_W-1] ? (~req_data.sample + 1'b1)
                                                 : req_data.sample;

   // shared multiplier, operands chosen by state
   always_comb begin
      mul_a = {MUL_A_W{1'b0}};
      mul_b = {MUL_B_W{1'b0}};
      case (state_ff)
         ST_SQUARE: begin
            mul_a = MUL_A_W'(mag_ff);
            mul_b = MUL_B_W'(mag_ff);
         end
         ST_GATE: begin
            mul_a = floor_ff;
            mul_b = MUL_B_W'(gate_ff);
         end
         ST_UPD_A: begin
            mul_a = floor_ff;
            mul_b = {1'b1, {WEIGHT_W{1'b0}}} - {1'b0, weight_ff};
         end
         ST_UPD_B: begin
            mul_a = root_ff;
            mul_b = MUL_B_W'(weight_ff);
         end
         ST_THR: begin
            mul_a = floor_ff;
            mul_b = MUL_B_W'(threshold_ff);
         end
         default: begin
            mul_a = {MUL_A_W{1'b0}};
            mul_b = {MUL_B_W{1'b0}};
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign acc_sum   = sum_ff + prod_ff;
   assign fill_next = fill_ff + 1'b1;

   // restoring divider step, one quotient bit a cycle
   assign div_trial    = {div_rem_ff, div_q_ff[SUM_W-1]};
   assign div_ge       = (div_trial >= eff_len);
   assign div_rem_next = div_ge ? DIV_REM_W'(div_trial - eff_len)
                                : div_trial[DIV_REM_W-1:0];
   assign div_q_next   = {div_q_ff[SUM_W-2:0], div_ge};

   // digit-by-digit root step, one root bit a cycle
   assign sq_trial    = {sq_rem_ff, sq_val_ff[SQ_W-1 -: 2]};
   assign sq_test     = {1'b0, root_ff, 2'b01};
   assign sq_ge       = (sq_trial >= sq_test);
   assign sq_rem_next = sq_ge ? SQ_REM_W'(sq_trial - sq_test)
                              : sq_trial[SQ_REM_W-1:0];
   assign root_next   = {root_ff[ROOT_W-2:0], sq_ge};

   assign rms_scaled = PROD_W'({root_ff, 8'h00});
   assign upd_sum    = {1'b0, acc_ff} + {1'b0, prod_ff};

   always_comb begin
      state_in        = state_ff;
      frame_length_in = frame_length_ff;
      threshold_in    = threshold_ff;
      gate_in         = gate_ff;
      weight_in       = weight_ff;
      sum_in          = sum_ff;
      fill_in         = fill_ff;
      floor_in        = floor_ff;
      speech_on_in    = speech_on_ff;
      seen_in         = seen_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      mag_in          = mag_ff;
      last_in         = last_ff;
      prod_in         = prod_ff;
      acc_in          = acc_ff;
      cnt_in          = cnt_ff;
      div_q_in        = div_q_ff;
      div_rem_in      = div_rem_ff;
      sq_val_in       = sq_val_ff;
      sq_rem_in       = sq_rem_ff;
      root_in         = root_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_LENGTH:     frame_length_in = csr_wdata[LEN_W-1:0];
            CSR_THRESHOLD_FACTOR: threshold_in    = csr_wdata[FACTOR_W-1:0];
            CSR_GATE_FACTOR:      gate_in         = csr_wdata[FACTOR_W-1:0];
            CSR_TRACKING_WEIGHT:  weight_in       = csr_wdata[WEIGHT_W-1:0];
            default:              weight_in       = weight_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mag_in  = req_mag;
               last_in = req_data.chunk_end;
               if (!seen_ff) begin
                  state_in = ST_SQUARE;
               end else if (req_data.chunk_end) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SQUARE: begin
            prod_in  = mul_p;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (fill_next >= eff_len) begin
               sum_in     = '0;
               fill_in    = '0;
               div_q_in   = acc_sum;
               div_rem_in = '0;
               cnt_in     = '0;
               state_in   = ST_DIV;
            end else begin
               sum_in   = acc_sum;
               fill_in  = fill_next;
               state_in = last_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_DIV: begin
            div_q_in   = div_q_next;
            div_rem_in = div_rem_next;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               sq_val_in = {1'b0, div_q_next[MEAN_W-1:0], 16'h0000};
               sq_rem_in = '0;
               root_in   = '0;
               cnt_in    = '0;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_val_in = {sq_val_ff[SQ_W-3:0], 2'b00};
            sq_rem_in = sq_rem_next;
            root_in   = root_next;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = ST_GATE;
            end
         end
         ST_GATE: begin
            prod_in  = mul_p;
            state_in = ST_GATE_CMP;
         end
         ST_GATE_CMP: begin
            if (!speech_on_ff && (rms_scaled < prod_ff)) begin
               state_in = ST_UPD_A;
            end else begin
               state_in = ST_THR;
            end
         end
         ST_UPD_A: begin
            prod_in  = mul_p;
            state_in = ST_UPD_B;
         end
         ST_UPD_B: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = ST_UPD_C;
         end
         ST_UPD_C: begin
            floor_in = upd_sum[FLOOR_W+15:16];
            state_in = ST_THR;
         end
         ST_THR: begin
            prod_in  = mul_p;
            state_in = ST_THR_CMP;
         end
         ST_THR_CMP: begin
            if (rms_scaled > prod_ff) begin
               seen_in = 1'b1;
            end
            state_in = last_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.speech_active  = seen_ff;
               rsp_data_in.speech_started = seen_ff && !speech_on_ff;
               rsp_data_in.speech_ended   = !seen_ff && speech_on_ff;
               rsp_data_in.noise_floor    = (floor_ff > OUT_FLOOR_MAX)
                                            ? OUT_FLOOR_MAX[OUT_FLOOR_W-1:0]
                                            : floor_ff[OUT_FLOOR_W-1:0];
               speech_on_in = seen_ff;
               seen_in      = 1'b0;
               sum_in       = '0;
               fill_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_length_ff <= FRAME_LENGTH_RESET;
         threshold_ff    <= THRESHOLD_FACTOR_RESET;
         gate_ff         <= GATE_FACTOR_RESET;
         weight_ff       <= TRACKING_WEIGHT_RESET;
         sum_ff          <= '0;
         fill_ff         <= '0;
         floor_ff        <= FLOOR_RESET;
         speech_on_ff    <= 1'b0;
         seen_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cnt_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         frame_length_ff <= frame_length_in;
         threshold_ff    <= threshold_in;
         gate_ff         <= gate_in;
         weight_ff       <= weight_in;
         sum_ff          <= sum_in;
         fill_ff         <= fill_in;
         floor_ff        <= floor_in;
         speech_on_ff    <= speech_on_in;
         seen_ff         <= seen_in;
         rsp_valid_ff    <= rsp_valid_in;
         cnt_ff          <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      mag_ff      <= mag_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      div_q_ff    <= div_q_in;
      div_rem_ff  <= div_rem_in;
      sq_val_ff   <= sq_val_in;
      sq_rem_ff   <= sq_rem_in;
      root_ff     <= root_in;
   end

`ifndef ASSERT_OFF
   // floor is a weighted mean of values no larger than 2^23
   a_floor_range: assert property (@(posedge clock) disable iff (reset)
      floor_ff <= FLOOR_W'(24'h800000))
      else $error("noise floor out of range");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.speech_started && rsp_data_ff.speech_ended))
      else $error("start and end flagged together");

   a_started_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.speech_started |-> rsp_data_ff.speech_active)
      else $error("start without active speech");

   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) && (cnt_ff != '0)
         |-> ({1'b0, sq_rem_ff} <= {1'b0, root_ff, 1'b0}))
      else $error("root remainder exceeds bound");
`endif

endmodule

/* tb/tb_energy_voice_activity_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy voice activity detector testbench
// Drives sample words through the req channel and checks every per-chunk
// verdict on the rsp channel against an in-bench prediction of frame RMS,
// noise floor tracking and speech state. Directed cases cover register
// extremes, frame closure on the chunk end, partial frames, speech latching
// and the saturated frame length; random chunks follow under random
// configurations, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_energy_voice_activity_detector;
   import evad_pkg::*;

   localparam int unsigned HALF_PERIOD  = 5;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned ITEM_TARGET  = 1150;
   localparam logic [OUT_FLOOR_W-1:0] OUT_FLOOR_MAX = '1;

   typedef enum {QUIET_CHUNK, LOUD_CHUNK, BURST_CHUNK, RAW_CHUNK} chunk_kind_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predicted block state
   logic [LEN_W-1:0]    cfg_frame_len = FRAME_LENGTH_RESET;
   logic [FACTOR_W-1:0] cfg_threshold = THRESHOLD_FACTOR_RESET;
   logic [FACTOR_W-1:0] cfg_gate      = GATE_FACTOR_RESET;
   logic [WEIGHT_W-1:0] cfg_weight    = TRACKING_WEIGHT_RESET;
   logic [SUM_W-1:0]    energy_sum       = '0;
   int unsigned         frame_fill_cnt   = 0;
   logic [FLOOR_W-1:0]  floor_q8         = FLOOR_RESET;
   bit                  speech_state     = 1'b0;
   bit                  chunk_has_speech = 1'b0;

   rsp_word_type verdicts[$];
   int unsigned  fault_count = 0;
   int unsigned  fed_items   = 0;
   int unsigned  idle_cycles = 0;
   bit           calm        = 1'b0;

   energy_voice_activity_detector uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int unsigned idle_len();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [FLOOR_W-1:0] int_sqrt(input logic [47:0] v);
      logic [FLOOR_W-1:0] r;
      logic [FLOOR_W-1:0] t;
      r = '0;
      for (int b = FLOOR_W - 1; b >= 0; b--) begin
         t = r | (24'd1 << b);
         if (48'(t) * 48'(t) <= v) r = t;
      end
      return r;
   endfunction

   // RMS in Q16.8, floor tracking, then the threshold test on the new floor
   function automatic bit frame_is_speech(input int unsigned len);
      logic [63:0] mean;
      logic [63:0] rms;
      logic [63:0] fl;
      mean = 64'(energy_sum) / 64'(len);
      rms  = 64'(int_sqrt(48'(mean << 16)));
      fl   = 64'(floor_q8);
      if (!speech_state && rms * 64'd256 < fl * 64'(cfg_gate)) begin
         fl = (fl * (64'd65536 - 64'(cfg_weight)) + rms * 64'(cfg_weight)) >> 16;
         floor_q8 = fl[FLOOR_W-1:0];
      end
      return rms * 64'd256 > 64'(floor_q8) * 64'(cfg_threshold);
   endfunction

   task automatic track_sample(input req_word_type w);
      int unsigned  len;
      longint       mag;
      rsp_word_type v;
      if (!chunk_has_speech) begin
         mag = longint'(w.sample);
         if (mag < 0) mag = -mag;
         len = 32'(cfg_frame_len);
         if (len == 0) len = 1;
         else if (len > MAX_FRAME_LEN) len = MAX_FRAME_LEN;
         energy_sum += SUM_W'(mag * mag);
         frame_fill_cnt++;
         if (frame_fill_cnt >= len) begin
            if (frame_is_speech(len)) chunk_has_speech = 1'b1;
            energy_sum     = '0;
            frame_fill_cnt = 0;
         end
      end
      if (w.chunk_end) begin
         v.speech_active  = chunk_has_speech;
         v.speech_started = chunk_has_speech && !speech_state;
         v.speech_ended   = !chunk_has_speech && speech_state;
         v.noise_floor    = (floor_q8 > FLOOR_W'(OUT_FLOOR_MAX)) ? OUT_FLOOR_MAX
                                                                 : floor_q8[OUT_FLOOR_W-1:0];
         speech_state     = chunk_has_speech;
         chunk_has_speech = 1'b0;
         energy_sum       = '0;
         frame_fill_cnt   = 0;
         verdicts.push_back(v);
      end
   endtask

   task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic last);
      req_word_type w;
      int unsigned  n;
      w.sample    = smp;
      w.chunk_end = last;
      n = idle_len();
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fed_items++;
      track_sample(w);
   endtask

   task automatic send_chunk(input int unsigned count, input chunk_kind_type kind);
      int amp;
      logic signed [SAMPLE_W-1:0] smp;
      for (int unsigned i = 0; i < count; i++) begin
         case (kind)
            QUIET_CHUNK: amp = $urandom_range(0, 300);
            LOUD_CHUNK:  amp = $urandom_range(400, 32767);
            BURST_CHUNK: amp = (i < count / 2) ? $urandom_range(0, 300)
                                               : $urandom_range(400, 32767);
            default:     amp = $urandom_range(0, 65535);
         endcase
         if (kind == RAW_CHUNK) smp = SAMPLE_W'(amp);
         else smp = $urandom_range(0, 1) ? SAMPLE_W'(-amp) : SAMPLE_W'(amp);
         send_word(smp, i == count - 1);
      end
   endtask

   // let the block go quiet: no word in flight and no verdict outstanding
   task automatic wait_drained(input int unsigned hold);
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts.size() != 0) @(posedge clock);
      repeat (hold) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      case (idx)
         CSR_FRAME_LENGTH:     cfg_frame_len = d[LEN_W-1:0];
         CSR_THRESHOLD_FACTOR: cfg_threshold = d[FACTOR_W-1:0];
         CSR_GATE_FACTOR:      cfg_gate      = d[FACTOR_W-1:0];
         CSR_TRACKING_WEIGHT:  cfg_weight    = d[WEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   // unused upper data bits carry noise
   task automatic write_config(input int unsigned len, input int unsigned thr,
                               input int unsigned gate, input int unsigned wt);
      logic [CSR_DATA_W-1:0] d;
      csr_write <= 1'b1;
      d = CSR_DATA_W'($urandom);
      d[LEN_W-1:0] = LEN_W'(len);
      put_reg(CSR_FRAME_LENGTH, d);
      d = CSR_DATA_W'($urandom);
      d[FACTOR_W-1:0] = FACTOR_W'(thr);
      put_reg(CSR_THRESHOLD_FACTOR, d);
      d = CSR_DATA_W'($urandom);
      d[FACTOR_W-1:0] = FACTOR_W'(gate);
      put_reg(CSR_GATE_FACTOR, d);
      put_reg(CSR_TRACKING_WEIGHT, CSR_DATA_W'(wt));
      csr_write <= 1'b0;
   endtask

   function automatic int unsigned pick_scaled(input int unsigned top, input int unsigned lo,
                                               input int unsigned hi);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 12) return 0;
      if (r < 24) return top;
      if (r < 40) return $urandom_range(0, top);
      return $urandom_range(lo, hi);
   endfunction

   task automatic test_reset_defaults();
      send_word(16'sd1200, 1'b0);
      send_word(-16'sd1200, 1'b0);
      send_word(16'sd77, 1'b1);
      send_word(16'sd5, 1'b1);
   endtask

   task automatic test_unit_frames();
      wait_drained(DRAIN_CYCLES);
      write_config(0, 768, 4095, 65535);
      send_word(16'sd32767, 1'b1);
      send_word(-16'sd32768, 1'b1);
      send_word(16'sd0, 1'b1);
      send_word(16'sd0, 1'b1);
      send_word(-16'sd32768, 1'b1);
      send_word(16'sd1, 1'b1);
   endtask

   task automatic test_speech_latch();
      wait_drained(DRAIN_CYCLES);
      calm = 1'b1;
      write_config(2, 256, 0, 0);
      send_word(16'sd20000, 1'b0);
      send_word(-16'sd20000, 1'b0);
      send_word(16'sd5, 1'b0);
      send_word(16'sd5, 1'b0);
      send_word(-16'sd7, 1'b1);
      send_word(16'sd10, 1'b0);
      send_word(16'sd10, 1'b0);
      send_word(16'sd10, 1'b1);
      calm = 1'b0;
   endtask

   task automatic test_factor_extremes();
      wait_drained(DRAIN_CYCLES);
      write_config(1, 4095, 4095, 32768);
      send_word(16'sd300, 1'b1);
      send_word(16'sd0, 1'b1);
      wait_drained(DRAIN_CYCLES);
      write_config(1, 0, 0, 65535);
      send_word(16'sd0, 1'b1);
      send_word(16'sd1, 1'b1);
   endtask

   // length 2047 clamps to the maximum frame, which closes on the chunk end
   task automatic test_max_frame();
      wait_drained(DRAIN_CYCLES);
      write_config(2047, 768, 307, 3277);
      for (int unsigned i = 0; i < MAX_FRAME_LEN; i++)
         send_word(-16'sd32768, i == MAX_FRAME_LEN - 1);
      send_chunk(5, LOUD_CHUNK);
   endtask

   // random chunks until the whole run reaches its word count
   task automatic test_random_traffic();
      int unsigned goal;
      int unsigned len;
      int unsigned eff;
      goal = ITEM_TARGET;
      while (fed_items < goal) begin
         wait_drained(DRAIN_CYCLES);
         calm = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = 1;
            default: len = $urandom_range(2, 12);
         endcase
         write_config(len, pick_scaled(4095, 128, 1536), pick_scaled(4095, 128, 1536),
                      pick_scaled(65535, 0, 65535));
         eff = (len == 0) ? 1 : len;
         for (int c = 0; c < 20 && fed_items < goal; c++) begin
            send_chunk($urandom_range(1, 3 * eff + 2),
                       chunk_kind_type'($urandom_range(0, 3)));
            if ($urandom_range(0, 19) == 0) wait_drained(0);
         end
      end
      calm = 1'b0;
   endtask

   task automatic check_field(input string field, input logic [OUT_FLOOR_W-1:0] want,
                              input logic [OUT_FLOOR_W-1:0] got);
      if (got !== want) begin
         fault_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : verdict_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts.size() == 0) begin
            fault_count++;
            $display("%0t: word with none expected, actual %p", $time, rsp_data);
         end else begin
            want = verdicts.pop_front();
            check_field("speech_active", OUT_FLOOR_W'(want.speech_active),
                        OUT_FLOOR_W'(rsp_data.speech_active));
            check_field("speech_started", OUT_FLOOR_W'(want.speech_started),
                        OUT_FLOOR_W'(rsp_data.speech_started));
            check_field("speech_ended", OUT_FLOOR_W'(want.speech_ended),
                        OUT_FLOOR_W'(rsp_data.speech_ended));
            check_field("noise_floor", want.noise_floor, rsp_data.noise_floor);
         end
      end
   end

   initial begin : rsp_stall_driver
      int unsigned n;
      forever begin
         @(posedge clock);
         n = idle_len();
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_unit_frames();
      test_speech_latch();
      test_factor_extremes();
      test_max_frame();
      test_random_traffic();
      wait_drained(DRAIN_CYCLES);
      if (fault_count == 0 && verdicts.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
design/evad_pkg.sv
design/energy_voice_activity_detector.sv
tb/tb_energy_voice_activity_detector.sv
